### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define LBPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication.
`define LBPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

### hw/rtl/lbps_pkg.sv
// Shared types, constants and state encodings of the light bar pair scorer.
package lbps_pkg;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned IDX_OUT_W  = 3;
    localparam int unsigned CONF_W     = 16;
    localparam int unsigned PAIR_CAP   = 28;
    localparam int unsigned PAIR_CNT_W = 5;
    localparam int unsigned SQRT_STEPS = 29;
    localparam int unsigned MAX_LIGHTS_DEF = 8;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_RATIO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_RATIO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_MIS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_MIS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MAX  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_MIN    = 3'd6;

    // 3*16384 score base plus 3*32768 offset that makes the sum non-negative
    localparam logic [17:0] CONF_OFFSET  = 18'd147456;
    // floor(u/3) = (u * RECIP3) >> RECIP3_SHIFT, exact for u < 2^18
    localparam logic [18:0] RECIP3       = 19'd349526;
    localparam int unsigned RECIP3_SHIFT = 20;

    typedef struct packed {
        logic [15:0]        x;
        logic [15:0]        y;
        logic [15:0]        len;
        logic signed [16:0] ang;
    } t_light;

    typedef struct packed {
        logic [15:0]        small_ratio;
        logic [15:0]        large_ratio;
        logic [15:0]        small_mis;
        logic [15:0]        large_mis;
        logic [15:0]        angle_max;
        logic [15:0]        height_max;
        logic signed [15:0] conf_min;
    } t_cfg;

    typedef enum logic [2:0] {F_IDLE, F_READ, F_PUSH, F_END, F_WAIT} t_front_state;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_PROD, S_SQRT, S_SPAN, S_CHECK,
        S_DIV, S_TOTAL, S_RECIP, S_CONF, S_OUT
    } t_score_state;

    typedef enum logic [1:0] {T_IDLE, T_INS, T_EMIT, T_NONE} t_sort_state;

endpackage

### hw/rtl/lbps_fifo.sv
// Two-entry job queue between the front end and the scorer.
module lbps_fifo import lbps_pkg::*; #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= !r_wr;
            if (do_pop)  r_rd <= !r_rd;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end
endmodule

### hw/rtl/lbps_front.sv
// Front end: light store, frame bookkeeping and pair job generation.
module lbps_front import lbps_pkg::*; #(
    parameter int unsigned MAX_LIGHTS = MAX_LIGHTS_DEF,
    localparam int unsigned IW = $clog2(MAX_LIGHTS),
    localparam int unsigned CW = $clog2(MAX_LIGHTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_light        i_light,
    input  logic          i_last,
    output logic          o_busy,
    output logic          o_job_valid,
    output logic          o_job_end,
    output logic          o_job_drop,
    output logic [IW-1:0] o_job_i,
    output logic [IW-1:0] o_job_j,
    output t_light        o_job_a,
    output t_light        o_job_b,
    input  logic          i_job_full,
    input  logic          i_done
);
    localparam int unsigned EW = CW + 1;

    t_front_state r_state, n_state;
    t_light       r_mem [MAX_LIGHTS];
    t_light       r_rd_a;
    t_light       r_rd_b;
    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic          accept;
    logic          has_room;
    logic [CW-1:0] cnt_after;
    logic [EW-1:0] j_next;
    logic [EW-1:0] i_next;
    logic          j_more;
    logic          i_more;

    assign accept    = i_start && (r_state == F_IDLE);
    assign has_room  = (r_cnt < CW'(MAX_LIGHTS));
    assign cnt_after = has_room ? r_cnt + CW'(1) : r_cnt;
    assign j_next    = EW'(r_j) + EW'(1);
    assign i_next    = EW'(r_i) + EW'(1);
    assign j_more    = (j_next < EW'(r_cnt));
    assign i_more    = ((i_next + EW'(1)) < EW'(r_cnt));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept && i_last) n_state = (cnt_after < CW'(2)) ? F_END : F_READ;
            F_READ: n_state = F_PUSH;
            F_PUSH: if (!i_job_full) n_state = (j_more || i_more) ? F_READ : F_END;
            F_END:  if (!i_job_full) n_state = F_WAIT;
            F_WAIT: if (i_done) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_busy      = (r_state != F_IDLE);
        o_job_valid = (r_state == F_PUSH) || (r_state == F_END);
        o_job_end   = (r_state == F_END);
    end

    assign o_job_drop = r_ovf;
    assign o_job_i    = r_i;
    assign o_job_j    = r_j;
    assign o_job_a    = r_rd_a;
    assign o_job_b    = r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= cnt_after;
                if (!has_room) r_ovf <= 1'b1;
                r_i <= '0;
                r_j <= IW'(1);
            end
            if (r_state == F_PUSH && !i_job_full) begin
                if (j_more) begin
                    r_j <= j_next[IW-1:0];
                end else begin
                    r_i <= i_next[IW-1:0];
                    r_j <= IW'(i_next + EW'(1));
                end
            end
            if (r_state == F_WAIT && i_done) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    // light store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (accept && has_room) r_mem[r_cnt[IW-1:0]] <= i_light;
        r_rd_a <= r_mem[r_i];
        r_rd_b <= r_mem[r_j];
    end
endmodule

### hw/rtl/lbps_div.sv
// Restoring divider, one quotient bit per cycle.
module lbps_div import lbps_pkg::*; #(
    parameter int unsigned NUM_W = 32,
    parameter int unsigned DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);
    localparam int unsigned SW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [SW-1:0]    r_step;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {r_rem, r_q[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, r_den});
    assign o_busy  = r_busy;
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + SW'(1);
            if (r_step == SW'(NUM_W - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(shifted - {1'b0, r_den}) : shifted[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], fits};
        end
    end
endmodule

### hw/rtl/lbps_score.sv
// Back end scorer: checks one pair and computes its confidence.
module lbps_score import lbps_pkg::*; #(
    parameter int unsigned MAX_LIGHTS = MAX_LIGHTS_DEF,
    localparam int unsigned IW = $clog2(MAX_LIGHTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_job_valid,
    input  logic               i_job_end,
    input  logic               i_job_drop,
    input  logic [IW-1:0]      i_job_i,
    input  logic [IW-1:0]      i_job_j,
    input  t_light             i_job_a,
    input  t_light             i_job_b,
    output logic               o_job_pop,
    output logic               o_valid,
    output logic               o_end,
    output logic               o_drop,
    output logic [IW-1:0]      o_left,
    output logic [IW-1:0]      o_right,
    output logic signed [15:0] o_conf,
    input  logic               i_ready
);
    t_score_state r_state, n_state;

    t_light        r_a, r_b;
    logic [IW-1:0] r_i, r_j;
    logic          r_end, r_drop;
    logic [31:0]   r_dx2, r_dy2;
    logic [16:0]   r_s;
    logic [15:0]   r_h, r_m;
    logic [17:0]   r_ad;
    logic [57:0]   r_sq;
    logic [28:0]   r_root;
    logic [31:0]   r_rem;
    logic [4:0]    r_step;
    logic [32:0]   r_e2s, r_e2l;
    logic [31:0]   r_hm;
    logic [28:0]   r_ed;
    logic [48:0]   r_ms, r_ml;
    logic [17:0]   r_u;
    logic [36:0]   r_prod;
    logic signed [15:0] r_conf;

    // pair difference terms
    logic [15:0]        dx, dy;
    logic signed [17:0] ad_s;
    // sqrt step
    logic [31:0]   sq_shift, sq_trial;
    logic          sq_fit;
    // checks
    logic [33:0]   d2, diff_s, diff_l;
    logic          ok_s, ok_l, pass;
    logic [28:0]   dd;
    logic [31:0]   ad_mul;
    // dividers
    logic          div_start;
    logic          busy_a, busy_h, busy_d;
    logic [30:0]   q_a, q_h;
    logic [42:0]   q_d;
    logic [43:0]   tot;
    logic [15:0]   q3;
    logic signed [15:0] conf_c;

    assign dx   = (r_a.x > r_b.x) ? r_a.x - r_b.x : r_b.x - r_a.x;
    assign dy   = (r_a.y > r_b.y) ? r_a.y - r_b.y : r_b.y - r_a.y;
    assign ad_s = 18'(r_a.ang) - 18'(r_b.ang);

    assign sq_shift = {r_rem[29:0], r_sq[57:56]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_fit   = (sq_shift >= sq_trial);

    // spacing: |2D - E2| * 4096 <= mismatch * E2, with E2 nonzero
    assign d2     = {4'b0, r_root, 1'b0};
    assign diff_s = (d2 > {1'b0, r_e2s}) ? d2 - {1'b0, r_e2s} : {1'b0, r_e2s} - d2;
    assign diff_l = (d2 > {1'b0, r_e2l}) ? d2 - {1'b0, r_e2l} : {1'b0, r_e2l} - d2;
    assign ok_s   = (r_e2s != '0) && ({3'b0, diff_s, 12'b0} <= r_ms);
    assign ok_l   = (r_e2l != '0) && ({3'b0, diff_l, 12'b0} <= r_ml);
    assign pass   = (ok_s || ok_l)
                 && (r_ad <= {2'b0, i_cfg.angle_max})
                 && (r_m != '0)
                 && ({8'b0, r_h, 12'b0} <= {4'b0, r_hm});

    assign dd     = (r_root > r_ed) ? r_root - r_ed : r_ed - r_root;
    assign ad_mul = {1'b0, r_ad, 13'b0} + {r_ad, 14'b0};

    assign div_start = (r_state == S_CHECK) && pass;

    lbps_div #(.NUM_W(31), .DEN_W(16)) u_div_ang (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(ad_mul[30:0]), .i_den(i_cfg.angle_max), .o_busy(busy_a), .o_quot(q_a)
    );
    lbps_div #(.NUM_W(31), .DEN_W(17)) u_div_hgt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({r_h, 15'b0}), .i_den(r_s), .o_busy(busy_h), .o_quot(q_h)
    );
    lbps_div #(.NUM_W(43), .DEN_W(29)) u_div_dst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({dd, 14'b0}), .i_den(r_ed), .o_busy(busy_d), .o_quot(q_d)
    );

    // zero angle limit: only equal angles pass, angle score stays full
    assign tot = ((i_cfg.angle_max == '0) ? 44'd0 : 44'(q_a)) + 44'(q_h) + 44'(q_d);

    assign q3     = r_prod[RECIP3_SHIFT +: 16];
    assign conf_c = {~q3[15], q3[14:0]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_job_valid) n_state = i_job_end ? S_OUT : S_PREP;
            S_PREP:  n_state = S_PROD;
            S_PROD:  n_state = S_SQRT;
            S_SQRT:  if (r_step == 5'(SQRT_STEPS - 1)) n_state = S_SPAN;
            S_SPAN:  n_state = S_CHECK;
            S_CHECK: n_state = pass ? S_DIV : S_IDLE;
            S_DIV:   if (!busy_a && !busy_h && !busy_d) n_state = S_TOTAL;
            S_TOTAL: n_state = S_RECIP;
            S_RECIP: n_state = S_CONF;
            S_CONF:  n_state = (conf_c >= i_cfg.conf_min) ? S_OUT : S_IDLE;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = (r_state == S_IDLE);
        o_valid   = (r_state == S_OUT);
    end

    assign o_end   = r_end;
    assign o_drop  = r_drop;
    assign o_left  = (r_a.x < r_b.x) ? r_i : r_j;
    assign o_right = (r_a.x < r_b.x) ? r_j : r_i;
    assign o_conf  = r_conf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_a    <= i_job_a;
                r_b    <= i_job_b;
                r_i    <= i_job_i;
                r_j    <= i_job_j;
                r_end  <= i_job_end;
                r_drop <= i_job_drop;
            end
            S_PREP: begin
                r_dx2 <= dx * dx;
                r_dy2 <= dy * dy;
                r_s   <= 17'(r_a.len) + 17'(r_b.len);
                r_h   <= (r_a.len > r_b.len) ? r_a.len - r_b.len : r_b.len - r_a.len;
                r_m   <= (r_a.len < r_b.len) ? r_a.len : r_b.len;
                r_ad  <= ad_s[17] ? 18'(-ad_s) : 18'(ad_s);
            end
            S_PROD: begin
                r_sq   <= {1'b0, 33'(r_dx2) + 33'(r_dy2), 24'b0};
                r_root <= '0;
                r_rem  <= '0;
                r_step <= '0;
                r_e2s  <= i_cfg.small_ratio * r_s;
                r_e2l  <= i_cfg.large_ratio * r_s;
                r_hm   <= i_cfg.height_max * r_m;
                r_ed   <= {1'b0, r_s, 11'b0} + {2'b0, r_s, 10'b0};
            end
            S_SQRT: begin
                r_rem  <= sq_fit ? sq_shift - sq_trial : sq_shift;
                r_root <= {r_root[27:0], sq_fit};
                r_sq   <= {r_sq[55:0], 2'b0};
                r_step <= r_step + 5'd1;
            end
            S_SPAN: begin
                r_ms <= i_cfg.small_mis * r_e2s;
                r_ml <= i_cfg.large_mis * r_e2l;
            end
            S_TOTAL: begin
                // below -2.0 after the divide by three saturates to u = 0
                r_u <= (tot > 44'(CONF_OFFSET)) ? 18'd0 : CONF_OFFSET - tot[17:0];
            end
            S_RECIP: r_prod <= r_u * RECIP3;
            S_CONF:  r_conf <= conf_c;
            default: ;
        endcase
    end
endmodule

### hw/rtl/lbps_sort.sv
// Sorted pair list: insertion one slot per cycle, then result emission.
module lbps_sort import lbps_pkg::*; #(
    parameter int unsigned MAX_LIGHTS = MAX_LIGHTS_DEF,
    localparam int unsigned IW = $clog2(MAX_LIGHTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_end,
    input  logic                 i_drop,
    input  logic [IW-1:0]        i_left,
    input  logic [IW-1:0]        i_right,
    input  logic signed [15:0]   i_conf,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [IDX_OUT_W-1:0] o_left,
    output logic [IDX_OUT_W-1:0] o_right,
    output logic signed [15:0]   o_conf,
    output logic                 o_last,
    output logic                 o_none,
    output logic                 o_drop,
    output logic                 o_done
);
    localparam int unsigned XW = IW + IDX_OUT_W;

    t_sort_state r_state, n_state;

    logic [IW-1:0]         r_lft [PAIR_CAP];
    logic [IW-1:0]         r_rgt [PAIR_CAP];
    logic signed [15:0]    r_cnf [PAIR_CAP];
    logic [PAIR_CNT_W-1:0] r_cnt, r_k, r_e;
    logic [IW-1:0]         r_new_l, r_new_r;
    logic signed [15:0]    r_new_c;
    logic                  r_drop;
    logic                  r_o_valid, r_o_last, r_o_none, r_o_drop;
    logic [IDX_OUT_W-1:0]  r_o_left, r_o_right;
    logic signed [15:0]    r_o_conf;

    logic                  full;
    logic                  lowest_wins;
    logic [PAIR_CNT_W-1:0] rd_addr;
    logic [IW-1:0]         rd_l, rd_r;
    logic signed [15:0]    rd_c;
    logic                  shift_on;
    logic                  emit_last;
    logic [XW-1:0]         ext_l, ext_r;

    assign full        = (r_cnt == PAIR_CNT_W'(PAIR_CAP));
    assign lowest_wins = (r_cnf[PAIR_CAP-1] >= i_conf);
    assign rd_addr     = (r_state == T_EMIT) ? r_e : r_k - PAIR_CNT_W'(1);
    assign rd_l        = r_lft[rd_addr];
    assign rd_r        = r_rgt[rd_addr];
    assign rd_c        = r_cnf[rd_addr];
    assign shift_on    = (r_k != '0) && (rd_c < r_new_c);
    assign emit_last   = (r_e == r_cnt - PAIR_CNT_W'(1));
    assign ext_l       = XW'(rd_l);
    assign ext_r       = XW'(rd_r);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: begin
                if (i_valid) begin
                    if (i_end)                    n_state = (r_cnt == '0) ? T_NONE : T_EMIT;
                    else if (!(full && lowest_wins)) n_state = T_INS;
                end
            end
            T_INS:  if (!shift_on) n_state = T_IDLE;
            T_EMIT: if (emit_last) n_state = T_IDLE;
            T_NONE: n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == T_IDLE);
    end

    assign o_valid = r_o_valid;
    assign o_left  = r_o_left;
    assign o_right = r_o_right;
    assign o_conf  = r_o_conf;
    assign o_last  = r_o_last;
    assign o_none  = r_o_none;
    assign o_drop  = r_o_drop;
    assign o_done  = r_o_valid && r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= T_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= (r_state == T_EMIT) || (r_state == T_NONE);
            if (r_state == T_INS && !shift_on && !full) r_cnt <= r_cnt + PAIR_CNT_W'(1);
            if (r_state == T_EMIT && emit_last)         r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            T_IDLE: begin
                r_new_l <= i_left;
                r_new_r <= i_right;
                r_new_c <= i_conf;
                r_k     <= full ? PAIR_CNT_W'(PAIR_CAP - 1) : r_cnt;
                r_e     <= '0;
                if (i_valid && i_end) r_drop <= i_drop;
            end
            T_INS: begin
                if (shift_on) begin
                    r_lft[r_k] <= rd_l;
                    r_rgt[r_k] <= rd_r;
                    r_cnf[r_k] <= rd_c;
                    r_k        <= r_k - PAIR_CNT_W'(1);
                end else begin
                    r_lft[r_k] <= r_new_l;
                    r_rgt[r_k] <= r_new_r;
                    r_cnf[r_k] <= r_new_c;
                end
            end
            T_EMIT: begin
                r_o_left  <= ext_l[IDX_OUT_W-1:0];
                r_o_right <= ext_r[IDX_OUT_W-1:0];
                r_o_conf  <= rd_c;
                r_o_last  <= emit_last;
                r_o_none  <= 1'b0;
                r_o_drop  <= r_drop;
                r_e       <= r_e + PAIR_CNT_W'(1);
            end
            T_NONE: begin
                r_o_left  <= '0;
                r_o_right <= '0;
                r_o_conf  <= '0;
                r_o_last  <= 1'b1;
                r_o_none  <= 1'b1;
                r_o_drop  <= r_drop;
            end
            default: ;
        endcase
    end
endmodule

### hw/rtl/light_bar_pair_scorer.sv
// Light bar pair scorer top level: config registers, front end, job queue, scorer, sorter.
// A light without last_light is accepted and busy stays low; the last light raises busy
// until the final result strobe. Each pair goes through a 29-step square root; one that
// passes then goes through the dividers (the longest of 43 steps) and into the sorted list.
// Results then leave one per cycle, in descending confidence. No back-pressure.
// Reset (synchronous, active low) clears the frame, the queue and config to defaults.
module light_bar_pair_scorer import lbps_pkg::*; #(
    parameter int unsigned MAX_LIGHTS = MAX_LIGHTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [15:0]           i_light_x,
    input  logic [15:0]           i_light_y,
    input  logic [15:0]           i_light_length,
    input  logic signed [16:0]    i_light_angle,
    input  logic                  i_last_light,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output logic                  o_valid,
    output logic [IDX_OUT_W-1:0]  o_left_index,
    output logic [IDX_OUT_W-1:0]  o_right_index,
    output logic signed [15:0]    o_pair_confidence,
    output logic                  o_last_pair,
    output logic                  o_none_found,
    output logic                  o_lights_dropped
);
    localparam int unsigned IW = $clog2(MAX_LIGHTS);
    localparam int unsigned LW = $bits(t_light);
    // job transaction: end marker, overflow flag, two load positions, two lights
    localparam int unsigned JW = 2 + 2 * IW + 2 * LW;

    t_cfg r_cfg;
    t_light in_light;

    // front -> queue
    logic          f_valid, f_end, f_drop;
    logic [IW-1:0] f_i, f_j;
    t_light        f_a, f_b;
    logic          q_full;
    logic [JW-1:0] q_in, q_out;
    logic          q_valid;

    // queue -> scorer
    logic          s_pop;
    logic          j_end, j_drop;
    logic [IW-1:0] j_i, j_j;
    t_light        j_a, j_b;

    // scorer -> sorter
    logic               p_valid, p_end, p_drop, p_ready;
    logic [IW-1:0]      p_left, p_right;
    logic signed [15:0] p_conf;
    logic               frame_done;

    // configuration registers; to be written only while the block is idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.small_ratio <= 16'd9874;
            r_cfg.large_ratio <= 16'd16823;
            r_cfg.small_mis   <= 16'd1229;
            r_cfg.large_mis   <= 16'd1229;
            r_cfg.angle_max   <= 16'd2560;
            r_cfg.height_max  <= 16'd2048;
            r_cfg.conf_min    <= 16'sd8192;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SMALL_RATIO: r_cfg.small_ratio <= i_cfg_data;
                CFG_LARGE_RATIO: r_cfg.large_ratio <= i_cfg_data;
                CFG_SMALL_MIS:   r_cfg.small_mis   <= i_cfg_data;
                CFG_LARGE_MIS:   r_cfg.large_mis   <= i_cfg_data;
                CFG_ANGLE_MAX:   r_cfg.angle_max   <= i_cfg_data;
                CFG_HEIGHT_MAX:  r_cfg.height_max  <= i_cfg_data;
                CFG_CONF_MIN:    r_cfg.conf_min    <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign in_light.x   = i_light_x;
    assign in_light.y   = i_light_y;
    assign in_light.len = i_light_length;
    assign in_light.ang = i_light_angle;

    // front end: stores lights, walks pairs (i < j) on the last light, then an end marker
    lbps_front #(.MAX_LIGHTS(MAX_LIGHTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_light     (in_light),
        .i_last      (i_last_light),
        .o_busy      (busy),
        .o_job_valid (f_valid),
        .o_job_end   (f_end),
        .o_job_drop  (f_drop),
        .o_job_i     (f_i),
        .o_job_j     (f_j),
        .o_job_a     (f_a),
        .o_job_b     (f_b),
        .i_job_full  (q_full),
        .i_done      (frame_done)
    );

    assign q_in = {f_end, f_drop, f_i, f_j, f_a, f_b};

    lbps_fifo #(.WIDTH(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (s_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {j_end, j_drop, j_i, j_j, j_a, j_b} = q_out;

    // back end: checks and scores one pair at a time, passes the end marker through
    lbps_score #(.MAX_LIGHTS(MAX_LIGHTS)) u_score (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (q_valid),
        .i_job_end   (j_end),
        .i_job_drop  (j_drop),
        .i_job_i     (j_i),
        .i_job_j     (j_j),
        .i_job_a     (j_a),
        .i_job_b     (j_b),
        .o_job_pop   (s_pop),
        .o_valid     (p_valid),
        .o_end       (p_end),
        .o_drop      (p_drop),
        .o_left      (p_left),
        .o_right     (p_right),
        .o_conf      (p_conf),
        .i_ready     (p_ready)
    );

    // sorted list; on the end marker it emits the frame and signals completion
    lbps_sort #(.MAX_LIGHTS(MAX_LIGHTS)) u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid),
        .i_end   (p_end),
        .i_drop  (p_drop),
        .i_left  (p_left),
        .i_right (p_right),
        .i_conf  (p_conf),
        .o_ready (p_ready),
        .o_valid (o_valid),
        .o_left  (o_left_index),
        .o_right (o_right_index),
        .o_conf  (o_pair_confidence),
        .o_last  (o_last_pair),
        .o_none  (o_none_found),
        .o_drop  (o_lights_dropped),
        .o_done  (frame_done)
    );
endmodule

### hw/rtl/lbps_checker.sv
// Port-level checker for the light bar pair scorer, with its bind.
`include "assert_macros.svh"
module lbps_checker import lbps_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 i_last_light,
    input logic                 o_valid,
    input logic [IDX_OUT_W-1:0] o_left_index,
    input logic [IDX_OUT_W-1:0] o_right_index,
    input logic signed [15:0]   o_pair_confidence,
    input logic                 o_last_pair,
    input logic                 o_none_found
);
    `LBPS_ASSERT_IMP(a_result_in_frame, i_clk, i_rst_n, o_valid, busy)
    `LBPS_ASSERT_IMP(a_none_is_last, i_clk, i_rst_n, o_valid && o_none_found, o_last_pair)
    `LBPS_ASSERT_IMP(a_none_zero, i_clk, i_rst_n, o_valid && o_none_found,
        o_left_index == '0 && o_right_index == '0 && o_pair_confidence == '0)
    `LBPS_ASSERT_IMP(a_busy_ends_on_last, i_clk, i_rst_n, $fell(busy),
        $past(o_valid && o_last_pair))
    `LBPS_ASSERT_NEXT(a_plain_light_no_busy, i_clk, i_rst_n,
        start && !busy && !i_last_light, !busy)
endmodule

bind light_bar_pair_scorer lbps_checker u_lbps_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_last_light      (i_last_light),
    .o_valid           (o_valid),
    .o_left_index      (o_left_index),
    .o_right_index     (o_right_index),
    .o_pair_confidence (o_pair_confidence),
    .o_last_pair       (o_last_pair),
    .o_none_found      (o_none_found)
);

### test/tb_light_bar_pair_scorer.sv
// Testbench for light_bar_pair_scorer: directed and random frames checked against a predictor.
module tb_light_bar_pair_scorer;
    import lbps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one light as the predictor keeps it
    typedef struct {
        bit [15:0] x;
        bit [15:0] y;
        bit [15:0] len;
        int        ang;
    } light_rec_t;

    // one result of the block
    typedef struct {
        bit [2:0]  left;
        bit [2:0]  right;
        bit [15:0] conf;
        bit        last;
        bit        none;
        bit        dropped;
    } pair_rec_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [15:0]          i_light_x;
    logic [15:0]          i_light_y;
    logic [15:0]          i_light_length;
    logic signed [16:0]   i_light_angle;
    logic                 i_last_light;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_valid;
    logic [2:0]           o_left_index;
    logic [2:0]           o_right_index;
    logic signed [15:0]   o_pair_confidence;
    logic                 o_last_pair;
    logic                 o_none_found;
    logic                 o_lights_dropped;

    light_bar_pair_scorer u_dut (.*);

    // predictor copy of the registers
    bit [15:0]   small_ratio, large_ratio, small_mis, large_mis, angle_max, height_max;
    int          conf_min;
    // predictor copy of the frame
    light_rec_t  frame_lights[MAX_LIGHTS_DEF];
    int          frame_cnt;
    bit          frame_ovf;

    pair_rec_t   pending_pairs[$];
    int          mismatch_cnt;
    bit          idle_en;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------- predictor ----------------

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int b = 29; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic longint unsigned udiff(input longint unsigned a, input longint unsigned b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic bit spacing_near(input longint unsigned d2, input longint unsigned s,
                                        input longint unsigned ratio,
                                        input longint unsigned mis);
        longint unsigned e2;
        e2 = ratio * s;
        if (e2 == 0) return 0;
        return udiff(d2, e2) * 4096 <= mis * e2;
    endfunction

    // scores pair (i,j); returns 0 when a check rejects it
    function automatic bit score_lights(input int i, input int j, output int conf);
        longint unsigned dx, dy, d, l1, l2, s, ad, h, m, ed;
        longint sa, sh, sd, sum, c;
        dx = udiff(frame_lights[i].x, frame_lights[j].x);
        dy = udiff(frame_lights[i].y, frame_lights[j].y);
        d  = root_floor((dx * dx + dy * dy) << 24);
        l1 = frame_lights[i].len;
        l2 = frame_lights[j].len;
        s  = l1 + l2;
        sa = longint'(frame_lights[i].ang) - longint'(frame_lights[j].ang);
        ad = sa < 0 ? -sa : sa;
        h  = udiff(l1, l2);
        m  = l1 < l2 ? l1 : l2;
        conf = 0;
        if (!spacing_near(2 * d, s, small_ratio, small_mis) &&
            !spacing_near(2 * d, s, large_ratio, large_mis)) return 0;
        if (ad > angle_max) return 0;
        if (m == 0) return 0;
        if (h * 4096 > longint'(height_max) * m) return 0;
        sa = 16384;
        if (angle_max != 0) sa -= longint'(ad * 24576 / angle_max);
        sh = 16384 - longint'(h * 32768 / s);
        ed = 3072 * s;
        sd = 16384 - longint'(udiff(d, ed) * 16384 / ed);
        sum = sa + sh + sd;
        c = sum >= 0 ? sum / 3 : -((-sum + 2) / 3);
        if (c < -32768) c = -32768;
        conf = int'(c);
        return 1;
    endfunction

    // called for every accepted light; queues the frame's results on the last one
    function automatic void predict_light(input light_rec_t lt, input bit last);
        pair_rec_t ranked[$];
        pair_rec_t pr;
        int        conf, p, lft;
        if (frame_cnt < MAX_LIGHTS_DEF) begin
            frame_lights[frame_cnt] = lt;
            frame_cnt++;
        end else begin
            frame_ovf = 1;
        end
        if (!last) return;
        for (int i = 0; i < frame_cnt; i++) begin
            for (int j = i + 1; j < frame_cnt; j++) begin
                if (score_lights(i, j, conf) && conf >= conf_min) begin
                    // equal x: the later light is left
                    lft        = frame_lights[i].x < frame_lights[j].x ? i : j;
                    pr.left    = 3'(lft);
                    pr.right   = 3'(lft == i ? j : i);
                    pr.conf    = conf[15:0];
                    pr.none    = 0;
                    pr.dropped = frame_ovf;
                    pr.last    = 0;
                    p = 0;
                    while (p < ranked.size() && $signed(ranked[p].conf) >= conf) p++;
                    if (p < PAIR_CAP) begin
                        ranked.insert(p, pr);
                        if (ranked.size() > PAIR_CAP) void'(ranked.pop_back());
                    end
                end
            end
        end
        if (ranked.size() == 0) begin
            pr = '{left: 0, right: 0, conf: 0, last: 1, none: 1, dropped: frame_ovf};
            ranked.insert(ranked.size(), pr);
        end else begin
            ranked[ranked.size() - 1].last = 1;
        end
        foreach (ranked[k]) pending_pairs.insert(pending_pairs.size(), ranked[k]);
        frame_cnt = 0;
        frame_ovf = 0;
    endfunction

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        pair_rec_t want;
        if (i_rst_n && o_valid) begin
            if (pending_pairs.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR %0t: unexpected result L=%0d R=%0d conf=%0d",
                             $realtime, o_left_index, o_right_index, o_pair_confidence);
            end else begin
                want = pending_pairs.pop_front();
                if (o_left_index !== want.left || o_right_index !== want.right ||
                    o_pair_confidence !== want.conf || o_last_pair !== want.last ||
                    o_none_found !== want.none || o_lights_dropped !== want.dropped) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("ERROR %0t: exp L=%0d R=%0d conf=%0d last=%0b none=%0b drop=%0b",
                                 $realtime, want.left, want.right, $signed(want.conf),
                                 want.last, want.none, want.dropped);
                        $display("      got L=%0d R=%0d conf=%0d last=%0b none=%0b drop=%0b",
                                 o_left_index, o_right_index, o_pair_confidence,
                                 o_last_pair, o_none_found, o_lights_dropped);
                    end
                end
            end
        end
    end

    // ---------------- driver tasks ----------------

    // one light transaction; entered and left right after a rising edge, start left high
    task automatic send_light(input bit [15:0] x, input bit [15:0] y, input bit [15:0] len,
                              input int ang, input bit last);
        light_rec_t lt;
        int         gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_light_x      <= x;
        i_light_y      <= y;
        i_light_length <= len;
        i_light_angle  <= ang[16:0];
        i_last_light   <= last;
        // busy only moves on rising edges, so the falling edge shows the accept condition
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
        lt = '{x: x, y: y, len: len, ang: ang};
        predict_light(lt, last);
    endtask

    // idle the block: stop sending, wait for every pending result, then let the tail settle
    task automatic wait_results_done();
        start <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SMALL_RATIO: small_ratio = val;
            CFG_LARGE_RATIO: large_ratio = val;
            CFG_SMALL_MIS:   small_mis   = val;
            CFG_LARGE_MIS:   large_mis   = val;
            CFG_ANGLE_MAX:   angle_max   = val;
            CFG_HEIGHT_MAX:  height_max  = val;
            CFG_CONF_MIN:    conf_min    = int'($signed(val));
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input bit [15:0] sr, input bit [15:0] lr, input bit [15:0] sm,
                                  input bit [15:0] lm, input bit [15:0] am, input bit [15:0] hm,
                                  input bit [15:0] cm);
        write_reg(CFG_SMALL_RATIO, sr);
        write_reg(CFG_LARGE_RATIO, lr);
        write_reg(CFG_SMALL_MIS, sm);
        write_reg(CFG_LARGE_MIS, lm);
        write_reg(CFG_ANGLE_MAX, am);
        write_reg(CFG_HEIGHT_MAX, hm);
        write_reg(CFG_CONF_MIN, cm);
    endtask

    function automatic int rand_angle();
        return int'($urandom_range(0, 92160)) - 46080;
    endfunction

    // a frame of n lights laid out like a real plate row: spacing follows the ratios,
    // lengths and angles close, with some noise lights mixed in
    task automatic send_plate_frame(input int n);
        int          xs, len, ang, yb, step, ratio, lj;
        bit [15:0]   xv;
        xs  = $urandom_range(0, 4000);
        len = $urandom_range(32, 1600);
        ang = int'($urandom_range(0, 8000)) - 4000;
        yb  = $urandom_range(0, 65535);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 6) == 0) begin
                send_light(16'($urandom), 16'($urandom), 16'($urandom), rand_angle(),
                           k == n - 1);
            end else begin
                lj = len + int'($urandom_range(0, len / 5)) - len / 10;
                xv = xs > 65535 ? 16'hFFFF : xs[15:0];
                send_light(xv, 16'(yb + int'($urandom_range(0, 40))), lj[15:0],
                           ang + int'($urandom_range(0, 600)) - 300, k == n - 1);
                ratio = $urandom_range(0, 1) ? small_ratio : large_ratio;
                step  = ratio * len / 4096;
                xs   += step + int'($urandom_range(0, step / 10 + 1)) - step / 20;
            end
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_field_extremes();
        // single light: nothing to pair
        send_light(16'h0000, 16'h0000, 16'h0000, -46080, 1'b1);
        // two lights at opposite corners, extreme angles
        send_light(16'hFFFF, 16'hFFFF, 16'hFFFF, 46080, 1'b0);
        send_light(16'h0000, 16'h0000, 16'hFFFF, -46080, 1'b1);
        // a clean small-plate pair
        send_light(16'd1000, 16'd500, 16'd400, 0, 1'b0);
        send_light(16'd1964, 16'd500, 16'd400, 100, 1'b1);
        // equal x: the later light is left; zero length rejects its pairs
        send_light(16'd3000, 16'd100, 16'd400, 0, 1'b0);
        send_light(16'd3000, 16'd1064, 16'd400, 0, 1'b0);
        send_light(16'd5000, 16'd100, 16'd0, 0, 1'b1);
        // good large-plate pair, then its angle broken
        send_light(16'd200, 16'd200, 16'd300, 256, 1'b0);
        send_light(16'd1432, 16'd200, 16'd300, 256, 1'b1);
        send_light(16'd200, 16'd200, 16'd300, 46080, 1'b0);
        send_light(16'd1432, 16'd200, 16'd300, -46080, 1'b1);
        wait_results_done();
    endtask

    task automatic test_overflow();
        // ten, then eleven lights: the lights beyond eight are dropped and every result is flagged
        send_plate_frame(10);
        send_plate_frame(11);
        wait_results_done();
    endtask

    task automatic test_register_extremes();
        // zero angle limit: only equal angles pass
        write_all_regs(16'd9874, 16'd16823, 16'd2000, 16'd2000, 16'd0, 16'd4096, 16'h8000);
        send_light(16'd1000, 16'd500, 16'd400, 512, 1'b0);
        send_light(16'd1964, 16'd500, 16'd400, 512, 1'b0);
        send_light(16'd2928, 16'd500, 16'd400, 513, 1'b1);
        wait_results_done();
        // everything wide open, lowest threshold: all eight lights, up to 28 pairs
        write_all_regs(16'd9874, 16'd16823, 16'hFFFF, 16'hFFFF, 16'd46080, 16'hFFFF, 16'h8000);
        repeat (3) send_plate_frame(8);
        wait_results_done();
        // zero ratios: no spacing ever passes
        write_all_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd46080, 16'hFFFF, 16'h8000);
        repeat (2) send_plate_frame(6);
        wait_results_done();
        // tightest limits and the highest threshold
        write_all_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd0, 16'h4000);
        repeat (2) send_plate_frame(5);
        wait_results_done();
    endtask

    task automatic test_random_frames(input int n_items);
        int sent, n, next_cfg;
        sent     = 0;
        next_cfg = 90;
        while (sent < n_items) begin
            if (sent >= next_cfg) begin
                // new random setting now and then, block idle first
                next_cfg += 90;
                wait_results_done();
                write_all_regs(16'($urandom_range(4000, 20000)),
                               16'($urandom_range(4000, 20000)),
                               16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                               16'($urandom_range(1, 46080)), 16'($urandom_range(0, 8192)),
                               16'(int'($urandom_range(0, 24576)) - 8192));
            end
            n = $urandom_range(0, 9) == 0 ? $urandom_range(9, 11) : $urandom_range(1, 8);
            send_plate_frame(n);
            sent += n;
        end
        wait_results_done();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_light_x      = '0;
        i_light_y      = '0;
        i_light_length = '0;
        i_light_angle  = '0;
        i_last_light   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        small_ratio = 16'd9874;
        large_ratio = 16'd16823;
        small_mis   = 16'd1229;
        large_mis   = 16'd1229;
        angle_max   = 16'd2560;
        height_max  = 16'd2048;
        conf_min    = 8192;
        frame_cnt    = 0;
        frame_ovf    = 0;
        mismatch_cnt = 0;
        idle_en      = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_field_extremes();
        test_overflow();
        test_register_extremes();
        // back to defaults written explicitly
        write_all_regs(16'd9874, 16'd16823, 16'd1229, 16'd1229, 16'd2560, 16'd2048, 16'd8192);
        test_random_frames(140);
        // wider thresholds so more pairs come through
        write_all_regs(16'd9874, 16'd16823, 16'd3000, 16'd3000, 16'd6000, 16'd6000, 16'hE000);
        test_random_frames(80);
        // final stretch without idling
        idle_en = 1'b0;
        test_random_frames(60);

        if (mismatch_cnt == 0 && pending_pairs.size() == 0) begin
            $display("tb_light_bar_pair_scorer: PASS");
        end else begin
            $display("tb_light_bar_pair_scorer: FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #30ms;
        $display("tb_light_bar_pair_scorer: FAIL");
        $finish;
    end

endmodule
